### rtl/signal_routing_matrix_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the routing matrix checker
// Expects clk_i and rst_ni to be visible where a macro is used.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_ROUTING_MATRIX_ASSERT_SVH
`define SIGNAL_ROUTING_MATRIX_ASSERT_SVH

// Same-cycle implication, skipped while in reset
`define SRM_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("routing matrix check failed");

// Next-cycle implication, skipped while in reset
`define SRM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("routing matrix check failed");

`endif

### rtl/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types, command codes and select-line helpers of the routing matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

  // Matrix size
  localparam int unsigned OUTPUTS = 10;
  localparam int unsigned INPUTS  = 10;

  // Field widths
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned IDX_N  = 1 << IDX_W;
  localparam int unsigned MASK_W = 10;

  localparam logic [IDX_W-1:0] OUT_LIM  = IDX_W'(OUTPUTS);
  localparam logic [IDX_W-1:0] IN_LIM   = IDX_W'(INPUTS);
  localparam logic [IDX_W-1:0] OUT_LAST = IDX_W'(OUTPUTS - 1);
  localparam logic [IDX_W-1:0] NONE_SEL = '1;

  // Command codes
  localparam logic [3:0] FN_SET        = 4'd0;
  localparam logic [3:0] FN_UNROUTE    = 4'd1;
  localparam logic [3:0] FN_PICK_OUT   = 4'd2;
  localparam logic [3:0] FN_PICK_IN    = 4'd3;
  localparam logic [3:0] FN_ROUTE_PEND = 4'd4;
  localparam logic [3:0] FN_TOGGLE     = 4'd5;
  localparam logic [3:0] FN_QUERY      = 4'd6;
  localparam logic [3:0] FN_SCAN       = 4'd7;
  localparam logic [3:0] FN_REFRESH    = 4'd8;

  // Port A bits of the first two inputs
  localparam logic [1:0] SEL_A_IN0 = 2'b10;
  localparam logic [1:0] SEL_A_IN1 = 2'b01;

  // Port B bit position of inputs 3..10 (0x08,0x04,0x02,0x01,0x80,0x40,0x20,0x10)
  localparam logic [2:0] PORT_B_POS [8] = '{3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4};

  typedef struct packed {
    logic [3:0]       func;
    logic [IDX_W-1:0] out_index;
    logic [IDX_W-1:0] in_index;
    logic [7:0]       scan_a;
    logic [7:0]       scan_b;
  } srm_req_t;

  typedef struct packed {
    logic              drive_valid;
    logic [IDX_W-1:0]  drive_out;
    logic [1:0]        select_a;
    logic [7:0]        select_b;
    logic [MASK_W-1:0] out_mask;
    logic [MASK_W-1:0] pending_mask;
    logic [IDX_W-1:0]  in_of_out;
    logic              routed;
    logic [MASK_W-1:0] activity_by_in;
    logic [MASK_W-1:0] activity_by_out;
    logic              last;
  } srm_rsp_t;

  typedef struct packed {
    logic [1:0] a;
    logic [7:0] b;
  } srm_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             step;
    logic [IDX_W-1:0] cnt;
  } srm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;
    logic multi;
    logic out_free;
  } srm_sts_t;

  // Select lines of one input; none and lineless inputs give zero
  function automatic srm_sel_t srm_select(logic [IDX_W-1:0] src);
    srm_sel_t s;
    s = '0;
    if (src == IDX_W'(0)) begin
      s.a = SEL_A_IN0;
    end else if (src == IDX_W'(1)) begin
      s.a = SEL_A_IN1;
    end else if (src < IDX_W'(10) && src < IN_LIM) begin
      s.b = 8'(1) << PORT_B_POS[3'(src - IDX_W'(2))];
    end
    return s;
  endfunction

  // Active inputs from the active-low scan bytes, one bit per input code
  function automatic logic [IDX_N-1:0] srm_active(logic [7:0] sa, logic [7:0] sb);
    logic [IDX_N-1:0] act;
    act = '0;
    for (int i = 0; i < IDX_N; i++) begin
      if (i < int'(INPUTS)) begin
        if (i == 0) act[i] = ~sa[1];
        else if (i == 1) act[i] = ~sa[0];
        else if (i < 10) act[i] = ~sb[PORT_B_POS[3'(i - 2)]];
      end
    end
    return act;
  endfunction

endpackage

`default_nettype wire

### rtl/srm_datapath.sv
// ----------------------------------------------------------------------------
// srm_datapath
// Route table, pending selections, result formation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srm_pkg::srm_req_t  req_i,
  input  srm_pkg::srm_cmd_t  cmd_i,
  output srm_pkg::srm_sts_t  sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output srm_pkg::srm_rsp_t  out_rsp_o
);

  srm_pkg::srm_req_t req_q;
  logic [srm_pkg::IDX_W-1:0] table_q [srm_pkg::OUTPUTS];
  logic [srm_pkg::IDX_W-1:0] table_d [srm_pkg::OUTPUTS];
  logic [srm_pkg::IDX_W-1:0] pend_out_q, pend_out_d;
  logic [srm_pkg::IDX_W-1:0] pend_in_q, pend_in_d;
  logic                      out_valid_q;
  srm_pkg::srm_rsp_t         rsp_q, rsp_d;

  logic [srm_pkg::IDX_W-1:0]  rd_addr, cur, wr_val, pkey, drv_src;
  logic                       o_ok, i_ok, po_ok, pi_ok, wr_en, has, drv;
  logic [srm_pkg::MASK_W-1:0] q_mask, p_mask, by_out;
  logic [srm_pkg::IDX_N-1:0]  act;
  srm_pkg::srm_sel_t          sel;

  // Hold the accepted request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  // Range checks and the addressed table read
  always_comb begin
    o_ok  = req_q.out_index < srm_pkg::OUT_LIM;
    i_ok  = req_q.in_index < srm_pkg::IN_LIM;
    po_ok = pend_out_q < srm_pkg::OUT_LIM;
    pi_ok = pend_in_q < srm_pkg::IN_LIM;
    case (req_q.func)
      srm_pkg::FN_ROUTE_PEND: rd_addr = pend_out_q;
      srm_pkg::FN_REFRESH:    rd_addr = cmd_i.cnt;
      default:                rd_addr = req_q.out_index;
    endcase
    cur = (rd_addr < srm_pkg::OUT_LIM) ? table_q[rd_addr] : srm_pkg::NONE_SEL;
  end

  // Decode the command into table and pending updates
  always_comb begin
    has        = 1'b0;
    drv        = 1'b0;
    wr_en      = 1'b0;
    wr_val     = srm_pkg::NONE_SEL;
    pend_out_d = pend_out_q;
    pend_in_d  = pend_in_q;
    pkey       = pend_in_q;
    case (req_q.func)
      srm_pkg::FN_SET: begin
        has    = o_ok && i_ok;
        drv    = 1'b1;
        wr_en  = 1'b1;
        wr_val = req_q.in_index;
      end
      srm_pkg::FN_UNROUTE: begin
        has   = o_ok;
        drv   = 1'b1;
        wr_en = 1'b1;
      end
      srm_pkg::FN_PICK_OUT: begin
        has        = 1'b1;
        pend_out_d = o_ok ? req_q.out_index : srm_pkg::NONE_SEL;
        pend_in_d  = srm_pkg::NONE_SEL;
        pkey       = srm_pkg::NONE_SEL;
      end
      srm_pkg::FN_PICK_IN: begin
        has        = 1'b1;
        pend_in_d  = i_ok ? req_q.in_index : srm_pkg::NONE_SEL;
        pend_out_d = srm_pkg::NONE_SEL;
        pkey       = pend_in_d;
      end
      srm_pkg::FN_ROUTE_PEND: begin
        has    = po_ok && i_ok;
        drv    = 1'b1;
        wr_en  = 1'b1;
        wr_val = req_q.in_index;
      end
      srm_pkg::FN_TOGGLE: begin
        has    = pi_ok && o_ok;
        drv    = 1'b1;
        wr_en  = 1'b1;
        wr_val = (cur < srm_pkg::IN_LIM) ? srm_pkg::NONE_SEL : pend_in_q;
      end
      srm_pkg::FN_QUERY: begin
        has = 1'b1;
      end
      srm_pkg::FN_SCAN: begin
        has = 1'b1;
      end
      srm_pkg::FN_REFRESH: begin
        has = 1'b1;
        drv = 1'b1;
      end
      default: begin
        has = 1'b0;
      end
    endcase
  end

  // Compare every table entry against the queried and pending inputs and the scan activity
  always_comb begin
    act    = srm_pkg::srm_active(req_q.scan_a, req_q.scan_b);
    q_mask = '0;
    p_mask = '0;
    by_out = '0;
    for (int o = 0; o < int'(srm_pkg::OUTPUTS); o++) begin
      q_mask[o] = i_ok && (table_q[o] == req_q.in_index);
      p_mask[o] = (pkey < srm_pkg::IN_LIM) && (table_q[o] == pkey);
      by_out[o] = (table_q[o] < srm_pkg::IN_LIM) && act[table_q[o]];
    end
  end

  // Form the result
  always_comb begin
    drv_src = wr_en ? wr_val : cur;
    sel     = srm_pkg::srm_select(drv_src);
    rsp_d   = '0;
    case (req_q.func)
      srm_pkg::FN_PICK_OUT,
      srm_pkg::FN_PICK_IN: begin
        rsp_d.pending_mask = p_mask;
      end
      srm_pkg::FN_QUERY: begin
        rsp_d.out_mask     = q_mask;
        rsp_d.pending_mask = p_mask;
        rsp_d.routed       = o_ok && (cur < srm_pkg::IN_LIM);
        rsp_d.in_of_out    = rsp_d.routed ? cur : srm_pkg::IN_LIM;
      end
      srm_pkg::FN_SCAN: begin
        rsp_d.activity_by_in  = act[srm_pkg::MASK_W-1:0];
        rsp_d.activity_by_out = by_out;
      end
      default: begin
        rsp_d.drive_valid = drv;
        rsp_d.drive_out   = drv ? rd_addr : '0;
        rsp_d.select_a    = drv ? sel.a : '0;
        rsp_d.select_b    = drv ? sel.b : '0;
      end
    endcase
    rsp_d.last = (req_q.func != srm_pkg::FN_REFRESH) || (cmd_i.cnt == srm_pkg::OUT_LAST);
  end

  // Apply the table write on a step
  always_comb begin
    for (int o = 0; o < int'(srm_pkg::OUTPUTS); o++) begin
      table_d[o] = table_q[o];
    end
    if (cmd_i.step && wr_en) begin
      table_d[rd_addr] = wr_val;
    end
  end

  // Advance routing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int o = 0; o < int'(srm_pkg::OUTPUTS); o++) begin
        table_q[o] <= srm_pkg::NONE_SEL;
      end
      pend_out_q <= srm_pkg::NONE_SEL;
      pend_in_q  <= srm_pkg::NONE_SEL;
    end else if (cmd_i.step) begin
      table_q    <= table_d;
      pend_out_q <= pend_out_d;
      pend_in_q  <= pend_in_d;
    end
  end

  // Output register: load on a step, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.has_result = has;
  assign sts_o.multi      = (req_q.func == srm_pkg::FN_REFRESH);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign out_rsp_o        = rsp_q;

endmodule

`default_nettype wire

### rtl/srm_ctrl.sv
// ----------------------------------------------------------------------------
// srm_ctrl
// Request sequencer: takes a request, then steps out its results.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srm_pkg::srm_sts_t sts_i,
  output srm_pkg::srm_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state_q, state_d;
  logic [srm_pkg::IDX_W-1:0] cnt_q, cnt_d;

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_stall_o = (state_q != ST_IDLE);
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    cmd_o.cnt  = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          cnt_d      = '0;
        end
      end
      ST_RUN: begin
        if (!sts_i.has_result) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (!sts_i.multi || cnt_q == srm_pkg::OUT_LAST) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + srm_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### rtl/signal_routing_matrix.sv
// ----------------------------------------------------------------------------
// signal_routing_matrix
// 10-by-10 routing matrix with panel commands, queries, scan and refresh.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------
//  in      | in_valid_i / in_stall_o | in_req_i  (srm_req_t)
//  out     | out_valid_o/ out_stall_i| out_rsp_o (srm_rsp_t)
//
//  A request is taken, then the sequencer steps out its results one per
//  cycle while the output is not stalled, through the addressed route-table
//  read: one result for most requests, one per output for a refresh, and
//  none for a request that yields nothing. Reset leaves all outputs
//  unrouted and no pending selection. Output stall holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module signal_routing_matrix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srm_pkg::srm_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srm_pkg::srm_rsp_t out_rsp_o
);

  srm_pkg::srm_cmd_t cmd;
  srm_pkg::srm_sts_t sts;

  // Sequencer
  srm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Route table and result path
  srm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

### rtl/srm_checker.sv
// ----------------------------------------------------------------------------
// srm_checker
// Port-level checks of the routing matrix, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signal_routing_matrix_assert.svh"

module srm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input srm_pkg::srm_rsp_t out_rsp_o
);

  // Hold a stalled result
  `SRM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))

  // Drive results name a real output and at most one select line
  `SRM_ASSERT_SAME(a_drive_sel, out_valid_o && out_rsp_o.drive_valid, (out_rsp_o.drive_out < srm_pkg::OUT_LIM) && $onehot0({out_rsp_o.select_a, out_rsp_o.select_b}))

  // Non-drive results carry no select lines
  `SRM_ASSERT_SAME(a_no_drive, out_valid_o && !out_rsp_o.drive_valid, (out_rsp_o.select_a == '0) && (out_rsp_o.select_b == '0) && (out_rsp_o.drive_out == '0))

  // Keep refusing requests while a non-final result of a request waits
  `SRM_ASSERT_SAME(a_busy_mid, out_valid_o && !out_rsp_o.last, in_stall_o)

  // A routed answer names a real input
  `SRM_ASSERT_SAME(a_routed_src, out_valid_o && out_rsp_o.routed, out_rsp_o.in_of_out < srm_pkg::IN_LIM)

endmodule

bind signal_routing_matrix srm_checker u_srm_checker (.*);

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signal routing matrix. A queue of panel
// commands feeds a valid/stall driver. Each accepted request updates a
// local copy of the route table and pending selections, and the expected
// results are queued. A monitor compares every accepted result field by
// field, in order. Random idle bursts run on both channels, except in the
// final stretch of the run.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import srm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 24;

  // Port B line of inputs 3..10
  localparam logic [7:0] B_LINE [8] = '{8'h08, 8'h04, 8'h02, 8'h01,
                                        8'h80, 8'h40, 8'h20, 8'h10};

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  srm_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  srm_rsp_t out_rsp_o;

  signal_routing_matrix i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #2 clk_i = ~clk_i;

  // Local copy of the matrix state
  logic [IDX_W-1:0] route_tbl [OUTPUTS];
  logic [IDX_W-1:0] pend_out;
  logic [IDX_W-1:0] pend_in;

  srm_req_t cmd_q [$];
  srm_rsp_t rsp_due_q [$];

  int  n_queued   = 0;
  int  n_taken    = 0;
  int  n_rsp      = 0;
  int  n_errors   = 0;
  int  quiet_cyc  = 0;
  int  src_gap    = 0;
  int  snk_gap    = 0;
  bit  calm       = 1'b0;
  logic req_fire  = 1'b0;

  // Count a mismatch and print it
  task automatic report_mismatch(string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                n_rsp, name, got, want));
    end
  endtask

  // Select lines of one output, from the local route table
  function automatic srm_rsp_t drive_rsp(logic [IDX_W-1:0] o, logic fin);
    srm_rsp_t r;
    logic [IDX_W-1:0] src;
    r = '0;
    src = route_tbl[o];
    r.drive_valid = 1'b1;
    r.drive_out = o;
    if (src == 4'd0) begin
      r.select_a = SEL_A_IN0;
    end else if (src == 4'd1) begin
      r.select_a = SEL_A_IN1;
    end else if (src < 4'd10 && src < IN_LIM) begin
      r.select_b = B_LINE[3'(src - 4'd2)];
    end
    r.last = fin;
    return r;
  endfunction

  // Active-low scan bytes: is this input live
  function automatic logic input_live(logic [IDX_W-1:0] i, logic [7:0] sa, logic [7:0] sb);
    if (i == 4'd0) return !sa[1];
    if (i == 4'd1) return !sa[0];
    if (i < 4'd10 && i < IN_LIM) return ((~sb) & B_LINE[3'(i - 4'd2)]) != 8'h00;
    return 1'b0;
  endfunction

  // Outputs currently fed by one input
  function automatic logic [MASK_W-1:0] fed_mask(logic [IDX_W-1:0] src);
    logic [MASK_W-1:0] m;
    m = '0;
    if (src < IN_LIM) begin
      for (int o = 0; o < OUTPUTS; o++) begin
        if (route_tbl[o] == src) m[o] = 1'b1;
      end
    end
    return m;
  endfunction

  // Apply one accepted command to the local state, queue its results
  task automatic apply_command(srm_req_t req);
    srm_rsp_t r;
    logic o_ok;
    logic i_ok;
    logic [IDX_W-1:0] src;
    o_ok = req.out_index < OUT_LIM;
    i_ok = req.in_index < IN_LIM;
    r = '0;
    case (req.func)
      FN_SET: begin
        if (o_ok && i_ok) begin
          route_tbl[req.out_index] = req.in_index;
          rsp_due_q.push_back(drive_rsp(req.out_index, 1'b1));
        end
      end
      FN_UNROUTE: begin
        if (o_ok) begin
          route_tbl[req.out_index] = NONE_SEL;
          rsp_due_q.push_back(drive_rsp(req.out_index, 1'b1));
        end
      end
      FN_PICK_OUT, FN_PICK_IN: begin
        if (req.func == FN_PICK_OUT) begin
          pend_out = o_ok ? req.out_index : NONE_SEL;
          pend_in = NONE_SEL;
        end else begin
          pend_in = i_ok ? req.in_index : NONE_SEL;
          pend_out = NONE_SEL;
        end
        r.pending_mask = fed_mask(pend_in);
        r.last = 1'b1;
        rsp_due_q.push_back(r);
      end
      FN_ROUTE_PEND: begin
        if (pend_out < OUT_LIM && i_ok) begin
          route_tbl[pend_out] = req.in_index;
          rsp_due_q.push_back(drive_rsp(pend_out, 1'b1));
        end
      end
      FN_TOGGLE: begin
        if (pend_in < IN_LIM && o_ok) begin
          if (route_tbl[req.out_index] < IN_LIM) route_tbl[req.out_index] = NONE_SEL;
          else route_tbl[req.out_index] = pend_in;
          rsp_due_q.push_back(drive_rsp(req.out_index, 1'b1));
        end
      end
      FN_QUERY: begin
        src = o_ok ? route_tbl[req.out_index] : NONE_SEL;
        r.out_mask = fed_mask(req.in_index);
        r.pending_mask = fed_mask(pend_in);
        r.in_of_out = (src < IN_LIM) ? src : IN_LIM;
        r.routed = src < IN_LIM;
        r.last = 1'b1;
        rsp_due_q.push_back(r);
      end
      FN_SCAN: begin
        for (int i = 0; i < INPUTS && i < 10; i++) begin
          r.activity_by_in[i] = input_live(IDX_W'(i), req.scan_a, req.scan_b);
        end
        for (int o = 0; o < OUTPUTS; o++) begin
          src = route_tbl[o];
          r.activity_by_out[o] = src < IN_LIM && input_live(src, req.scan_a, req.scan_b);
        end
        r.last = 1'b1;
        rsp_due_q.push_back(r);
      end
      FN_REFRESH: begin
        for (int o = 0; o < OUTPUTS; o++) begin
          rsp_due_q.push_back(drive_rsp(IDX_W'(o), o == OUTPUTS - 1));
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_rsp(srm_rsp_t got, srm_rsp_t want);
    check_field("drive_valid", got.drive_valid, want.drive_valid);
    check_field("drive_out", got.drive_out, want.drive_out);
    check_field("select_a", got.select_a, want.select_a);
    check_field("select_b", got.select_b, want.select_b);
    check_field("out_mask", got.out_mask, want.out_mask);
    check_field("pending_mask", got.pending_mask, want.pending_mask);
    check_field("in_of_out", got.in_of_out, want.in_of_out);
    check_field("routed", got.routed, want.routed);
    check_field("activity_by_in", got.activity_by_in, want.activity_by_in);
    check_field("activity_by_out", got.activity_by_out, want.activity_by_out);
    check_field("last", got.last, want.last);
  endtask

  // Sample both channels, predict, check, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        apply_command(in_req_i);
        n_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (rsp_due_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", n_rsp));
        end else begin
          compare_rsp(out_rsp_o, rsp_due_q.pop_front());
        end
        n_rsp++;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cyc = 0;
      else quiet_cyc++;
      if (quiet_cyc >= STALL_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Drive requests at the falling edge, with idle bursts
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_fire)) begin
      if (src_gap > 0) begin
        in_valid_i <= 1'b0;
        src_gap--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        src_gap = $urandom_range(0, 16);
      end else if (cmd_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_req_i <= cmd_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the result channel in bursts
  always @(negedge clk_i) begin
    if (snk_gap > 0) begin
      out_stall_i <= 1'b1;
      snk_gap--;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      snk_gap = $urandom_range(0, 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [3:0] any_nibble();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly a real port, now and then an index past the end
  function automatic logic [3:0] some_index();
    if ($urandom_range(0, 4) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  function automatic logic [3:0] good_index();
    return 4'($urandom_range(0, 9));
  endfunction

  task automatic queue_cmd(logic [3:0] fn, logic [3:0] oi, logic [3:0] ii,
                           logic [7:0] sa, logic [7:0] sb);
    srm_req_t req;
    req.func = fn;
    req.out_index = oi;
    req.in_index = ii;
    req.scan_a = sa;
    req.scan_b = sb;
    cmd_q.push_back(req);
    n_queued++;
  endtask

  // Hold off until every request is taken and every result has come
  task automatic wait_idle();
    while (n_taken != n_queued) @(negedge clk_i);
    while (rsp_due_q.size() != 0) @(negedge clk_i);
  endtask

  // Mostly well-formed panel sequences with random content, some noise
  task automatic queue_random(int n);
    int done;
    int pick;
    int k;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        queue_cmd(FN_PICK_OUT, some_index(), any_nibble(), any_byte(), any_byte());
        queue_cmd(FN_ROUTE_PEND, any_nibble(), some_index(), any_byte(), any_byte());
        done += 2;
      end else if (pick < 28) begin
        queue_cmd(FN_PICK_IN, any_nibble(), some_index(), any_byte(), any_byte());
        k = $urandom_range(1, 3);
        repeat (k) begin
          queue_cmd(FN_TOGGLE, some_index(), any_nibble(), any_byte(), any_byte());
        end
        done += 1 + k;
      end else if (pick < 45) begin
        queue_cmd(FN_SET, good_index(), good_index(), any_byte(), any_byte());
        done++;
      end else if (pick < 54) begin
        queue_cmd(FN_UNROUTE, some_index(), any_nibble(), any_byte(), any_byte());
        done++;
      end else if (pick < 68) begin
        queue_cmd(FN_QUERY, some_index(), some_index(), any_byte(), any_byte());
        done++;
      end else if (pick < 80) begin
        queue_cmd(FN_SCAN, any_nibble(), any_nibble(), any_byte(), any_byte());
        done++;
      end else if (pick < 84) begin
        queue_cmd(FN_REFRESH, any_nibble(), any_nibble(), any_byte(), any_byte());
        done++;
      end else begin
        queue_cmd(any_nibble(), any_nibble(), any_nibble(), any_byte(), any_byte());
        done++;
      end
    end
  endtask

  initial begin
    for (int o = 0; o < OUTPUTS; o++) route_tbl[o] = NONE_SEL;
    pend_out = NONE_SEL;
    pend_in = NONE_SEL;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset state, edges of the index range, every command
    queue_cmd(FN_REFRESH, 4'd0, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_QUERY, 4'd0, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_ROUTE_PEND, 4'd0, 4'd3, 8'h00, 8'h00);
    queue_cmd(FN_TOGGLE, 4'd0, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_SET, 4'd0, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_SET, 4'd9, 4'd9, 8'hFF, 8'hFF);
    queue_cmd(FN_SET, 4'd1, 4'd1, 8'h00, 8'h00);
    queue_cmd(FN_SET, 4'd2, 4'd2, 8'h00, 8'h00);
    queue_cmd(FN_SET, 4'd10, 4'd3, 8'h00, 8'h00);
    queue_cmd(FN_SET, 4'd3, 4'd15, 8'h00, 8'h00);
    queue_cmd(FN_UNROUTE, 4'd15, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_UNROUTE, 4'd1, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_PICK_OUT, 4'd15, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_PICK_OUT, 4'd3, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_ROUTE_PEND, 4'd0, 4'd5, 8'h00, 8'h00);
    queue_cmd(FN_PICK_IN, 4'd0, 4'd9, 8'h00, 8'h00);
    queue_cmd(FN_TOGGLE, 4'd4, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_TOGGLE, 4'd9, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_QUERY, 4'd4, 4'd9, 8'h00, 8'h00);
    queue_cmd(FN_PICK_IN, 4'd0, 4'd12, 8'h00, 8'h00);
    queue_cmd(FN_QUERY, 4'd15, 4'd15, 8'h00, 8'h00);
    queue_cmd(FN_SCAN, 4'd0, 4'd0, 8'h00, 8'h00);
    queue_cmd(FN_SCAN, 4'd0, 4'd0, 8'hFF, 8'hFF);
    queue_cmd(FN_SCAN, 4'd0, 4'd0, 8'hA5, 8'h5A);
    queue_cmd(4'd9, 4'd0, 4'd0, 8'h00, 8'h00);
    queue_cmd(4'd15, 4'd15, 4'd15, 8'hFF, 8'hFF);
    queue_cmd(FN_REFRESH, 4'd0, 4'd0, 8'h00, 8'h00);
    wait_idle();

    // Random traffic, a full drain halfway, then a quiet final stretch
    queue_random(60);
    wait_idle();
    queue_random(60);
    wait_idle();
    calm = 1'b1;
    queue_random(25);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### signal_routing_matrix.f
+incdir+rtl
rtl/srm_pkg.sv
rtl/srm_datapath.sv
rtl/srm_ctrl.sv
rtl/signal_routing_matrix.sv
rtl/srm_checker.sv
tb/testbench.sv
